// ===== rtl/a2mu_pkg.sv =====
package a2mu_pkg;

    localparam int IN_W = 32;
    localparam int PC_W = 5;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CONCAT = 2'd1;
    localparam logic [1:0] OP_INVERT = 2'd2;
    localparam logic [1:0] OP_MAP    = 2'd3;

    // operand sources: stored matrix, given matrix, point
    localparam logic [3:0] S_SX  = 4'd0;
    localparam logic [3:0] S_KX  = 4'd1;
    localparam logic [3:0] S_TX  = 4'd2;
    localparam logic [3:0] S_KY  = 4'd3;
    localparam logic [3:0] S_SY  = 4'd4;
    localparam logic [3:0] S_TY  = 4'd5;
    localparam logic [3:0] S_GSX = 4'd6;
    localparam logic [3:0] S_GKX = 4'd7;
    localparam logic [3:0] S_GTX = 4'd8;
    localparam logic [3:0] S_GKY = 4'd9;
    localparam logic [3:0] S_GSY = 4'd10;
    localparam logic [3:0] S_GTY = 4'd11;
    localparam logic [3:0] S_PX  = 4'd12;
    localparam logic [3:0] S_PY  = 4'd13;

    localparam logic [2:0] IX_SX = 3'd0;
    localparam logic [2:0] IX_KX = 3'd1;
    localparam logic [2:0] IX_TX = 3'd2;
    localparam logic [2:0] IX_KY = 3'd3;
    localparam logic [2:0] IX_SY = 3'd4;
    localparam logic [2:0] IX_TY = 3'd5;

    typedef enum logic [3:0] {
        UOP_CLR    = 4'd0,
        UOP_MAC    = 4'd1,
        UOP_ADDT   = 4'd2,
        UOP_SETDET = 4'd3,
        UOP_NUM    = 4'd4,
        UOP_SHL    = 4'd5,
        UOP_WRR    = 4'd6,
        UOP_DIV    = 4'd7,
        UOP_COMMIT = 4'd8,
        UOP_LOAD   = 4'd9,
        UOP_MAPX   = 4'd10,
        UOP_MAPY   = 4'd11,
        UOP_END    = 4'd12
    } t_uop;

    typedef struct packed {
        t_uop       uop;
        logic [3:0] sa;
        logic [3:0] sb;
        logic       neg;
        logic [2:0] dst;
    } t_step;

    typedef struct packed {
        logic  capture;
        logic  issue;
        t_step step;
        logic  set_sing;
        logic  push;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic acc_zero;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [1:0]             opcode;
        logic signed [IN_W-1:0] coef_sx;
        logic signed [IN_W-1:0] coef_kx;
        logic signed [IN_W-1:0] coef_tx;
        logic signed [IN_W-1:0] coef_ky;
        logic signed [IN_W-1:0] coef_sy;
        logic signed [IN_W-1:0] coef_ty;
        logic signed [IN_W-1:0] point_x;
        logic signed [IN_W-1:0] point_y;
        logic                   point_last;
    } t_in_item;

    typedef struct packed {
        logic signed [IN_W-1:0] mapped_x;
        logic signed [IN_W-1:0] mapped_y;
        logic                   singular;
        logic                   batch_end;
    } t_out_item;

    function automatic t_step mk(input t_uop u, input logic [3:0] a, input logic [3:0] b,
                                 input logic n, input logic [2:0] d);
        t_step s;
        s.uop = u;
        s.sa  = a;
        s.sb  = b;
        s.neg = n;
        s.dst = d;
        return s;
    endfunction

    function automatic t_step step_at(input logic [1:0] op, input logic [PC_W-1:0] pc);
        t_step s;
        s = mk(UOP_END, S_SX, S_SX, 1'b0, IX_SX);
        case (op)
            OP_LOAD: begin
                case (pc)
                    5'd0:    s = mk(UOP_LOAD, S_SX, S_SX, 1'b0, IX_SX);
                    default: s = mk(UOP_END, S_SX, S_SX, 1'b0, IX_SX);
                endcase
            end
            OP_CONCAT: begin
                case (pc)
                    5'd0:    s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd1:    s = mk(UOP_MAC, S_SX, S_GSX, 1'b0, IX_SX);
                    5'd2:    s = mk(UOP_MAC, S_KX, S_GKY, 1'b0, IX_SX);
                    5'd3:    s = mk(UOP_WRR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd4:    s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd5:    s = mk(UOP_MAC, S_SX, S_GKX, 1'b0, IX_SX);
                    5'd6:    s = mk(UOP_MAC, S_KX, S_GSY, 1'b0, IX_SX);
                    5'd7:    s = mk(UOP_WRR, S_SX, S_SX, 1'b0, IX_KX);
                    5'd8:    s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd9:    s = mk(UOP_MAC, S_SX, S_GTX, 1'b0, IX_SX);
                    5'd10:   s = mk(UOP_MAC, S_KX, S_GTY, 1'b0, IX_SX);
                    5'd11:   s = mk(UOP_ADDT, S_TX, S_SX, 1'b0, IX_SX);
                    5'd12:   s = mk(UOP_WRR, S_SX, S_SX, 1'b0, IX_TX);
                    5'd13:   s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd14:   s = mk(UOP_MAC, S_KY, S_GSX, 1'b0, IX_SX);
                    5'd15:   s = mk(UOP_MAC, S_SY, S_GKY, 1'b0, IX_SX);
                    5'd16:   s = mk(UOP_WRR, S_SX, S_SX, 1'b0, IX_KY);
                    5'd17:   s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd18:   s = mk(UOP_MAC, S_KY, S_GKX, 1'b0, IX_SX);
                    5'd19:   s = mk(UOP_MAC, S_SY, S_GSY, 1'b0, IX_SX);
                    5'd20:   s = mk(UOP_WRR, S_SX, S_SX, 1'b0, IX_SY);
                    5'd21:   s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd22:   s = mk(UOP_MAC, S_KY, S_GTX, 1'b0, IX_SX);
                    5'd23:   s = mk(UOP_MAC, S_SY, S_GTY, 1'b0, IX_SX);
                    5'd24:   s = mk(UOP_ADDT, S_TY, S_SX, 1'b0, IX_SX);
                    5'd25:   s = mk(UOP_WRR, S_SX, S_SX, 1'b0, IX_TY);
                    5'd26:   s = mk(UOP_COMMIT, S_SX, S_SX, 1'b0, IX_SX);
                    default: s = mk(UOP_END, S_SX, S_SX, 1'b0, IX_SX);
                endcase
            end
            OP_INVERT: begin
                case (pc)
                    5'd0:    s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd1:    s = mk(UOP_MAC, S_SX, S_SY, 1'b0, IX_SX);
                    5'd2:    s = mk(UOP_MAC, S_KX, S_KY, 1'b1, IX_SX);
                    5'd3:    s = mk(UOP_SETDET, S_SX, S_SX, 1'b0, IX_SX);
                    5'd4:    s = mk(UOP_NUM, S_SY, S_SX, 1'b0, IX_SX);
                    5'd5:    s = mk(UOP_DIV, S_SX, S_SX, 1'b0, IX_SX);
                    5'd6:    s = mk(UOP_NUM, S_KX, S_SX, 1'b1, IX_SX);
                    5'd7:    s = mk(UOP_DIV, S_SX, S_SX, 1'b0, IX_KX);
                    5'd8:    s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd9:    s = mk(UOP_MAC, S_KX, S_TY, 1'b0, IX_SX);
                    5'd10:   s = mk(UOP_MAC, S_SY, S_TX, 1'b1, IX_SX);
                    5'd11:   s = mk(UOP_SHL, S_SX, S_SX, 1'b0, IX_SX);
                    5'd12:   s = mk(UOP_DIV, S_SX, S_SX, 1'b0, IX_TX);
                    5'd13:   s = mk(UOP_NUM, S_KY, S_SX, 1'b1, IX_SX);
                    5'd14:   s = mk(UOP_DIV, S_SX, S_SX, 1'b0, IX_KY);
                    5'd15:   s = mk(UOP_NUM, S_SX, S_SX, 1'b0, IX_SX);
                    5'd16:   s = mk(UOP_DIV, S_SX, S_SX, 1'b0, IX_SY);
                    5'd17:   s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd18:   s = mk(UOP_MAC, S_KY, S_TX, 1'b0, IX_SX);
                    5'd19:   s = mk(UOP_MAC, S_SX, S_TY, 1'b1, IX_SX);
                    5'd20:   s = mk(UOP_SHL, S_SX, S_SX, 1'b0, IX_SX);
                    5'd21:   s = mk(UOP_DIV, S_SX, S_SX, 1'b0, IX_TY);
                    5'd22:   s = mk(UOP_COMMIT, S_SX, S_SX, 1'b0, IX_SX);
                    default: s = mk(UOP_END, S_SX, S_SX, 1'b0, IX_SX);
                endcase
            end
            default: begin
                case (pc)
                    5'd0:    s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd1:    s = mk(UOP_MAC, S_SX, S_PX, 1'b0, IX_SX);
                    5'd2:    s = mk(UOP_MAC, S_KX, S_PY, 1'b0, IX_SX);
                    5'd3:    s = mk(UOP_ADDT, S_TX, S_SX, 1'b0, IX_SX);
                    5'd4:    s = mk(UOP_MAPX, S_SX, S_SX, 1'b0, IX_SX);
                    5'd5:    s = mk(UOP_CLR, S_SX, S_SX, 1'b0, IX_SX);
                    5'd6:    s = mk(UOP_MAC, S_KY, S_PX, 1'b0, IX_SX);
                    5'd7:    s = mk(UOP_MAC, S_SY, S_PY, 1'b0, IX_SX);
                    5'd8:    s = mk(UOP_ADDT, S_TY, S_SX, 1'b0, IX_SX);
                    5'd9:    s = mk(UOP_MAPY, S_SX, S_SX, 1'b0, IX_SX);
                    default: s = mk(UOP_END, S_SX, S_SX, 1'b0, IX_SX);
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/a2mu_ctrl.sv =====
module a2mu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_opcode,
    output logic                o_in_stall,
    output a2mu_pkg::t_cmd      o_cmd,
    input  a2mu_pkg::t_stat     i_stat
);
    import a2mu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [1:0]      r_op, n_op;
    t_step           step;

    assign step = step_at(r_op, r_pc);

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.step = step;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_op          = i_opcode;
                    n_pc          = '0;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                case (step.uop)
                    UOP_END: begin
                        n_state = ST_DONE;
                    end
                    UOP_SETDET: begin
                        o_cmd.issue = 1'b1;
                        if (i_stat.acc_zero) begin
                            o_cmd.set_sing = 1'b1;
                            n_state        = ST_DONE;
                        end else begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    UOP_MAC, UOP_DIV: begin
                        o_cmd.issue = 1'b1;
                        n_pc        = r_pc + 1'b1;
                        n_state     = ST_WAIT;
                    end
                    default: begin
                        o_cmd.issue = 1'b1;
                        n_pc        = r_pc + 1'b1;
                    end
                endcase
            end
            ST_WAIT: begin
                if (!i_stat.busy) begin
                    n_state = ST_RUN;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_op    <= OP_LOAD;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_op    <= n_op;
        end
    end

endmodule

// ===== rtl/a2mu_dp.sv =====
module a2mu_dp #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  a2mu_pkg::t_in_item  i_in_item,
    input  a2mu_pkg::t_cmd      i_cmd,
    output a2mu_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output a2mu_pkg::t_out_item o_out_item
);
    import a2mu_pkg::*;

    localparam int OW  = (COEF_WIDTH > IN_W) ? COEF_WIDTH : IN_W;
    localparam int AW  = 2 * OW + FRAC_BITS + 4;
    localparam int QB  = COEF_WIDTH + 1;
    localparam int QW  = QB + 1;
    localparam int DVW = AW + QB + 2;
    localparam int DCW = $clog2(QW + 1);

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [COEF_WIDTH-1:0] C_MAX = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0] C_MIN = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
    localparam logic signed [IN_W-1:0] O_MAX = {1'b0, {(IN_W - 1){1'b1}}};
    localparam logic signed [IN_W-1:0] O_MIN = {1'b1, {(IN_W - 1){1'b0}}};
    localparam logic signed [COEF_WIDTH-1:0] C_ONE = (FRAC_BITS <= COEF_WIDTH - 2) ?
        (COEF_WIDTH'(1) <<< FRAC_BITS) : C_MAX;

    logic signed [COEF_WIDTH-1:0] r_m [6];
    logic signed [COEF_WIDTH-1:0] r_t [6];
    logic signed [IN_W-1:0]       r_g [6];
    logic signed [IN_W-1:0]       r_px, r_py, r_rx, r_ry;
    logic                         r_last, r_sing;
    logic signed [AW-1:0]         r_acc, r_det, r_mcand;
    logic [OW-1:0]                r_mplier;
    logic                         r_mneg, r_mac_on;
    logic [DVW-1:0]               r_rem, r_dsh;
    logic [QW-1:0]                r_q;
    logic [DCW-1:0]               r_dcnt;
    logic                         r_dneg, r_div_on;
    logic [2:0]                   r_ddst;
    logic                         r_out_valid;
    t_out_item                    r_out;

    function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = v + HALF;
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] sat_c(input logic signed [AW-1:0] v);
        logic signed [COEF_WIDTH-1:0] r;
        if (!v[AW-1] && (|v[AW-2:COEF_WIDTH-1])) begin
            r = C_MAX;
        end else if (v[AW-1] && !(&v[AW-2:COEF_WIDTH-1])) begin
            r = C_MIN;
        end else begin
            r = v[COEF_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [IN_W-1:0] sat_o(input logic signed [AW-1:0] v);
        logic signed [IN_W-1:0] r;
        if (!v[AW-1] && (|v[AW-2:IN_W-1])) begin
            r = O_MAX;
        end else if (v[AW-1] && !(&v[AW-2:IN_W-1])) begin
            r = O_MIN;
        end else begin
            r = v[IN_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] sat_q(input logic [QW-1:0] q,
                                                           input logic neg);
        logic signed [COEF_WIDTH-1:0] r;
        if (!neg) begin
            if (q[QW-1] || q[QW-2] || q[COEF_WIDTH-1]) begin
                r = C_MAX;
            end else begin
                r = q[COEF_WIDTH-1:0];
            end
        end else begin
            if (q[QW-1] || q[QW-2] || (q[COEF_WIDTH-1] && (|q[COEF_WIDTH-2:0]))) begin
                r = C_MIN;
            end else begin
                r = -q[COEF_WIDTH-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic signed [OW-1:0] src(input logic [3:0] code);
        logic signed [OW-1:0] r;
        case (code)
            S_SX:    r = OW'(r_m[0]);
            S_KX:    r = OW'(r_m[1]);
            S_TX:    r = OW'(r_m[2]);
            S_KY:    r = OW'(r_m[3]);
            S_SY:    r = OW'(r_m[4]);
            S_TY:    r = OW'(r_m[5]);
            S_GSX:   r = OW'(r_g[0]);
            S_GKX:   r = OW'(r_g[1]);
            S_GTX:   r = OW'(r_g[2]);
            S_GKY:   r = OW'(r_g[3]);
            S_GSY:   r = OW'(r_g[4]);
            S_GTY:   r = OW'(r_g[5]);
            S_PX:    r = OW'(r_px);
            S_PY:    r = OW'(r_py);
            default: r = '0;
        endcase
        return r;
    endfunction

    logic signed [OW-1:0] op_a, op_b;
    logic [OW-1:0]        abs_a, abs_b;
    logic [AW-1:0]        abs_n, abs_d;
    logic                 issue_mac, issue_div, d_ge;
    logic [QW-1:0]        q_nx;

    assign op_a      = src(i_cmd.step.sa);
    assign op_b      = src(i_cmd.step.sb);
    assign abs_a     = op_a[OW-1] ? OW'(-op_a) : OW'(op_a);
    assign abs_b     = op_b[OW-1] ? OW'(-op_b) : OW'(op_b);
    assign abs_n     = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
    assign abs_d     = r_det[AW-1] ? AW'(-r_det) : AW'(r_det);
    assign issue_mac = i_cmd.issue && (i_cmd.step.uop == UOP_MAC);
    assign issue_div = i_cmd.issue && (i_cmd.step.uop == UOP_DIV);
    assign d_ge      = (r_rem >= r_dsh);
    assign q_nx      = {r_q[QW-2:0], d_ge};

    // accumulator, shift-add multiplier and small ops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_on <= 1'b0;
        end else if (r_mac_on) begin
            if (r_mplier == '0) begin
                r_mac_on <= 1'b0;
            end else begin
                if (r_mplier[0]) begin
                    r_acc <= r_mneg ? (r_acc - r_mcand) : (r_acc + r_mcand);
                end
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
            end
        end else if (i_cmd.issue) begin
            case (i_cmd.step.uop)
                UOP_CLR:    r_acc <= '0;
                UOP_MAC: begin
                    r_mac_on <= 1'b1;
                    r_mcand  <= AW'(abs_a);
                    r_mplier <= abs_b;
                    r_mneg   <= op_a[OW-1] ^ op_b[OW-1] ^ i_cmd.step.neg;
                end
                UOP_ADDT:   r_acc <= r_acc + (AW'(op_a) <<< FRAC_BITS);
                UOP_SETDET: r_det <= r_acc;
                UOP_NUM: begin
                    r_acc <= i_cmd.step.neg ? -(AW'(op_a) <<< (2 * FRAC_BITS))
                                            : (AW'(op_a) <<< (2 * FRAC_BITS));
                end
                UOP_SHL:    r_acc <= r_acc <<< FRAC_BITS;
                default: begin
                end
            endcase
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_on <= 1'b0;
        end else if (r_div_on) begin
            r_rem  <= d_ge ? (r_rem - r_dsh) : r_rem;
            r_dsh  <= r_dsh >> 1;
            r_q    <= q_nx;
            r_dcnt <= r_dcnt - 1'b1;
            if (r_dcnt == DCW'(1)) begin
                r_div_on <= 1'b0;
            end
        end else if (issue_div) begin
            r_div_on <= 1'b1;
            r_rem    <= (DVW'(abs_n) << 1) + DVW'(abs_d);
            r_dsh    <= DVW'(abs_d) << (QB + 1);
            r_q      <= '0;
            r_dcnt   <= DCW'(QW);
            r_dneg   <= r_acc[AW-1] ^ r_det[AW-1];
            r_ddst   <= i_cmd.step.dst;
        end
    end

    // stored and pending matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[0] <= C_ONE;
            r_m[1] <= '0;
            r_m[2] <= '0;
            r_m[3] <= '0;
            r_m[4] <= C_ONE;
            r_m[5] <= '0;
        end else if (i_cmd.issue && (i_cmd.step.uop == UOP_COMMIT)) begin
            for (int i = 0; i < 6; i++) begin
                r_m[i] <= r_t[i];
            end
        end else if (i_cmd.issue && (i_cmd.step.uop == UOP_LOAD)) begin
            for (int i = 0; i < 6; i++) begin
                r_m[i] <= sat_c(AW'(r_g[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_on && (r_dcnt == DCW'(1))) begin
            r_t[r_ddst] <= sat_q(q_nx, r_dneg);
        end else if (i_cmd.issue && (i_cmd.step.uop == UOP_WRR)) begin
            r_t[i_cmd.step.dst] <= sat_c(rnd(r_acc));
        end
    end

    // item capture and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_g[0] <= i_in_item.coef_sx;
            r_g[1] <= i_in_item.coef_kx;
            r_g[2] <= i_in_item.coef_tx;
            r_g[3] <= i_in_item.coef_ky;
            r_g[4] <= i_in_item.coef_sy;
            r_g[5] <= i_in_item.coef_ty;
            r_px   <= i_in_item.point_x;
            r_py   <= i_in_item.point_y;
            r_last <= (i_in_item.opcode == OP_MAP) && i_in_item.point_last;
            r_rx   <= '0;
            r_ry   <= '0;
            r_sing <= 1'b0;
        end else begin
            if (i_cmd.issue && (i_cmd.step.uop == UOP_MAPX)) begin
                r_rx <= sat_o(rnd(r_acc));
            end
            if (i_cmd.issue && (i_cmd.step.uop == UOP_MAPY)) begin
                r_ry <= sat_o(rnd(r_acc));
            end
            if (i_cmd.set_sing) begin
                r_sing <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out.mapped_x  <= r_rx;
            r_out.mapped_y  <= r_ry;
            r_out.singular  <= r_sing;
            r_out.batch_end <= r_last;
        end
    end

    assign o_stat.busy     = r_mac_on | r_div_on | issue_mac | issue_div;
    assign o_stat.acc_zero = (r_acc == '0);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;

endmodule

// ===== rtl/affine_2d_matrix_unit_top.sv =====
// 2x3 affine transform unit in signed fixed point (FRAC_BITS fraction bits, stored
// coefficients COEF_WIDTH bits, identity after reset). Each item carries an opcode:
// load, concat on the right, invert, map a point; every item gives one result item.
// Items are taken one at a time; a new item is taken while the previous result
// waits in the output register. Timing is set by a single shift-add multiplier, which
// stops after the highest set bit of its multiplier, and by a restoring divider.
// Load uses no products; map uses four products, concat twelve products, invert six
// products and six divides; a singular invert stops after the determinant.
module affine_2d_matrix_unit_top #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  a2mu_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output a2mu_pkg::t_out_item o_out_item
);
    import a2mu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    a2mu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_item.opcode),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    a2mu_dp #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import a2mu_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    affine_2d_matrix_unit_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    logic signed [31:0] mat_coef [6];
    t_out_item          result_q [$];
    int                 mismatches;
    int                 items_sent;
    int                 results_seen;
    int                 singular_seen;
    int                 op_count [4];
    bit                 idle_on;
    int                 hold_req;
    int                 hold_cnt;
    int                 stall_burst;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
        if (v > 128'sh7fff_ffff)
            return SMAX;
        if (v < -128'sh8000_0000)
            return SMIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] mac_round(input logic signed [31:0] a0,
                                                     input logic signed [31:0] b0,
                                                     input logic signed [31:0] a1,
                                                     input logic signed [31:0] b1,
                                                     input logic signed [31:0] t);
        logic signed [127:0] s;
        logic signed [127:0] x0, y0, x1, y1, tt;
        x0 = a0;
        y0 = b0;
        x1 = a1;
        y1 = b1;
        tt = t;
        s = x0 * y0 + x1 * y1 + (tt <<< 16);
        s = (s + 128'sd32768) >>> 16;
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] div_round(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
        logic [127:0] un, ud, q;
        logic         neg;
        neg = n[127] ^ d[127];
        un  = n[127] ? -n : n;
        ud  = d[127] ? -d : d;
        q   = (2 * un + ud) / (2 * ud);
        return sat32(neg ? -$signed(q) : $signed(q));
    endfunction

    function automatic t_out_item transform_step(input t_in_item it);
        t_out_item           r;
        logic signed [31:0]  s [6];
        logic signed [31:0]  g [6];
        logic signed [127:0] det, ntx, nty, w0, w1, w2, w3;
        r = '0;
        for (int i = 0; i < 6; i++)
            s[i] = mat_coef[i];
        g[0] = it.coef_sx;
        g[1] = it.coef_kx;
        g[2] = it.coef_tx;
        g[3] = it.coef_ky;
        g[4] = it.coef_sy;
        g[5] = it.coef_ty;
        op_count[it.opcode]++;
        case (it.opcode)
            OP_LOAD: begin
                for (int i = 0; i < 6; i++)
                    mat_coef[i] = g[i];
            end
            OP_CONCAT: begin
                mat_coef[0] = mac_round(s[0], g[0], s[1], g[3], 0);
                mat_coef[1] = mac_round(s[0], g[1], s[1], g[4], 0);
                mat_coef[2] = mac_round(s[0], g[2], s[1], g[5], s[2]);
                mat_coef[3] = mac_round(s[3], g[0], s[4], g[3], 0);
                mat_coef[4] = mac_round(s[3], g[1], s[4], g[4], 0);
                mat_coef[5] = mac_round(s[3], g[2], s[4], g[5], s[5]);
            end
            OP_INVERT: begin
                w0 = s[0];
                w1 = s[1];
                w2 = s[3];
                w3 = s[4];
                det = w0 * w3 - w1 * w2;
                if (det == 0) begin
                    r.singular = 1'b1;
                    singular_seen++;
                end else begin
                    ntx = (w1 * $signed(128'(s[5])) - w3 * $signed(128'(s[2]))) <<< 16;
                    nty = (w2 * $signed(128'(s[2])) - w0 * $signed(128'(s[5]))) <<< 16;
                    mat_coef[0] = div_round(w3 <<< 32, det);
                    mat_coef[1] = div_round(-(w1 <<< 32), det);
                    mat_coef[2] = div_round(ntx, det);
                    mat_coef[3] = div_round(-(w2 <<< 32), det);
                    mat_coef[4] = div_round(w0 <<< 32, det);
                    mat_coef[5] = div_round(nty, det);
                end
            end
            default: begin
                r.mapped_x  = mac_round(s[0], it.point_x, s[1], it.point_y, s[2]);
                r.mapped_y  = mac_round(s[3], it.point_x, s[4], it.point_y, s[5]);
                r.batch_end = it.point_last;
            end
        endcase
        return r;
    endfunction

    // receiver stall: long hold-off on request, else random bursts while idle_on is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cnt    = 0;
            stall_burst = 0;
        end else begin
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_stall <= 1'b1;
            end else if (!idle_on) begin
                i_out_stall <= 1'b0;
            end else if (stall_burst > 0) begin
                stall_burst--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_burst = $urandom_range(1, 7) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: got %h", o_out_item);
            end else begin
                want = result_q.pop_front();
                if (o_out_item.mapped_x !== want.mapped_x
                    || o_out_item.mapped_y !== want.mapped_y
                    || o_out_item.singular !== want.singular
                    || o_out_item.batch_end !== want.batch_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h s=%b e=%b act x=%h y=%h s=%b e=%b",
                                 want.mapped_x, want.mapped_y, want.singular, want.batch_end,
                                 o_out_item.mapped_x, o_out_item.mapped_y,
                                 o_out_item.singular, o_out_item.batch_end);
                end
            end
        end
    end

    task automatic send_item(input t_in_item it);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do
            @(posedge i_clk);
        while (o_in_stall);
        result_q.push_back(transform_step(it));
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_in_item mk_item(input logic [1:0] op,
                                         input logic signed [31:0] sx,
                                         input logic signed [31:0] kx,
                                         input logic signed [31:0] tx,
                                         input logic signed [31:0] ky,
                                         input logic signed [31:0] sy,
                                         input logic signed [31:0] ty,
                                         input logic signed [31:0] px,
                                         input logic signed [31:0] py,
                                         input logic last);
        t_in_item it;
        it.opcode     = op;
        it.coef_sx    = sx;
        it.coef_kx    = kx;
        it.coef_tx    = tx;
        it.coef_ky    = ky;
        it.coef_sy    = sy;
        it.coef_ty    = ty;
        it.point_x    = px;
        it.point_y    = py;
        it.point_last = last;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2:       return $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
            default: return $urandom_range(0, 1) ? ONE : -ONE;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        logic [1:0] op;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            op = OP_LOAD;
        else if (pick < 35)
            op = OP_CONCAT;
        else if (pick < 48)
            op = OP_INVERT;
        else
            op = OP_MAP;
        return mk_item(op, rand_val(), rand_val(), rand_val(), rand_val(), rand_val(),
                       rand_val(), rand_val(), rand_val(), 1'($urandom_range(0, 1)));
    endfunction

    task automatic test_directed();
        send_item(mk_item(OP_MAP, 0, 0, 0, 0, 0, 0, 32'sh0003_8000, -32'sh0001_2000, 1'b1));
        send_item(mk_item(OP_MAP, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMIN, 1'b0));
        send_item(mk_item(OP_LOAD, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, 0, 0, 1'b1));
        send_item(mk_item(OP_MAP, 0, 0, 0, 0, 0, 0, SMAX, SMAX, 1'b1));
        send_item(mk_item(OP_MAP, 0, 0, 0, 0, 0, 0, SMIN, SMIN, 1'b0));
        send_item(mk_item(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk_item(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_item(mk_item(OP_LOAD, ONE * 2, ONE, 0, ONE * 4, ONE * 2, 0, 0, 0, 1'b0));
        send_item(mk_item(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk_item(OP_LOAD, ONE * 2, 0, ONE * 3, 0, -ONE / 2, -ONE, 0, 0, 1'b0));
        send_item(mk_item(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk_item(OP_MAP, 0, 0, 0, 0, 0, 0, ONE, -ONE, 1'b1));
        send_item(mk_item(OP_CONCAT, ONE * 3, -ONE, ONE * 5, ONE / 4, ONE, -ONE * 7,
                          0, 0, 1'b1));
        send_item(mk_item(OP_MAP, 0, 0, 0, 0, 0, 0, 32'sh0000_0001, -32'sh0000_0001, 1'b0));
        send_item(mk_item(OP_LOAD, 1, 0, 0, 0, 1, 0, 0, 0, 1'b0));
        send_item(mk_item(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk_item(OP_LOAD, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0, 0, 1'b0));
        send_item(mk_item(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_item(mk_item(OP_CONCAT, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 0, 0, 1'b0));
        send_item(mk_item(OP_MAP, 0, 0, 0, 0, 0, 0, SMIN, SMAX, 1'b1));
        send_item(mk_item(OP_LOAD, ONE, 0, 0, 0, ONE, 0, 0, 0, 1'b0));
        wait_drained();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_item(rand_item());
    endtask

    task automatic test_backpressure();
        hold_req = 400;
        test_random(40);
    endtask

    task automatic test_sender_pause();
        test_random(30);
        wait_drained();
        test_random(30);
    endtask

    initial begin
        int wait_cnt;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        idle_on    = 1'b1;
        hold_req   = 0;
        mismatches = 0;
        items_sent = 0;
        results_seen  = 0;
        singular_seen = 0;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;
        mat_coef = '{ONE, 0, 0, 0, ONE, 0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(380);
        test_backpressure();
        test_sender_pause();
        idle_on = 1'b0;
        test_random(350);
        wait_drained();

        wait_cnt = 0;
        while (result_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (800) @(posedge i_clk);
        if (result_q.size() != 0)
            mismatches++;

        $display("%0d items sent (load %0d, concat %0d, invert %0d, map %0d), %0d results",
                 items_sent, op_count[0], op_count[1], op_count[2], op_count[3],
                 results_seen);
        $display("%0d singular inverts, %0d mismatches", singular_seen, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/a2mu_pkg.sv
rtl/a2mu_ctrl.sv
rtl/a2mu_dp.sv
rtl/affine_2d_matrix_unit_top.sv
dv/tb_top.sv
